/* hw/rtl/etu_pkg.sv */
// Shared types and constants for the Euler totient unit.
package etu_pkg;

	localparam int VALUE_BITS_DEF = 20;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_CHK,
		ST_DIVN,
		ST_EVN,
		ST_STN,
		ST_DIVA,
		ST_MUL,
		ST_DONE
	} etu_state_t;

	typedef enum logic [1:0] {
		DIV_N_BY_D,
		DIV_ACC_BY_D,
		DIV_ACC_BY_N
	} etu_div_sel_t;

	typedef struct packed {
		logic         load;
		logic         sq_en;
		logic         div_start;
		etu_div_sel_t div_sel;
		logic         n_take;
		logic         mul_en;
		logic         d_next;
	} etu_cmd_t;

	typedef struct packed {
		logic sq_le_n;
		logic n_gt1;
		logic rem_zero;
		logic div_done;
		logic div_busy;
	} etu_sts_t;

endpackage

/* hw/rtl/etu_value_if.sv */
// Input channel: valid/ready handshake carrying the value to factor.
interface etu_value_if #(
	parameter int VALUE_BITS = etu_pkg::VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

/* hw/rtl/etu_totient_if.sv */
// Output channel: valid/ready handshake carrying the totient result.
interface etu_totient_if #(
	parameter int VALUE_BITS = etu_pkg::VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] totient;

	modport source(output valid, output totient, input ready);
	modport sink(input valid, input totient, output ready);
endinterface

/* hw/rtl/etu_div.sv */
// Restoring divider, one quotient bit per cycle.
module etu_div #(
	parameter int VALUE_BITS = etu_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output logic [VALUE_BITS-1:0] quot,
	output logic [VALUE_BITS-1:0] rem,
	output logic                  busy,
	output logic                  done
);
	import etu_pkg::*;

	localparam int CW = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic [VALUE_BITS:0]   trial;

	assign trial = {rem_q, quo_q[VALUE_BITS-1]} - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(VALUE_BITS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!trial[VALUE_BITS]) begin
				rem_q <= trial[VALUE_BITS-1:0];
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[VALUE_BITS-2:0], quo_q[VALUE_BITS-1]};
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b0};
			end
		end
	end

	assign quot = quo_q;
	assign rem  = rem_q;
	assign busy = busy_q;
	assign done = busy_q && (cnt_q == '0);
endmodule

/* hw/rtl/etu_datapath.sv */
// Datapath: reduced n, running totient, trial divisor, square and divider.
module etu_datapath #(
	parameter int VALUE_BITS = etu_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  etu_pkg::etu_cmd_t     cmd,
	output etu_pkg::etu_sts_t     sts,
	input  logic [VALUE_BITS-1:0] in_value,
	output logic [VALUE_BITS-1:0] totient
);
	import etu_pkg::*;

	localparam int PW = 2 * VALUE_BITS;

	logic [VALUE_BITS-1:0] n_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic [VALUE_BITS-1:0] d_q;
	logic [VALUE_BITS-1:0] den_q;
	logic [PW-1:0]         sq_q;
	logic [VALUE_BITS-1:0] dividend;
	logic [VALUE_BITS-1:0] quot;
	logic [VALUE_BITS-1:0] rem;
	logic [PW-1:0]         prod;
	logic                  div_busy;
	logic                  div_done;

	assign dividend = (cmd.div_sel == DIV_N_BY_D) ? n_q : acc_q;
	// exact: den divides acc at this point
	assign prod     = PW'(quot) * PW'(den_q - VALUE_BITS'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= in_value;
			acc_q <= in_value;
			d_q   <= VALUE_BITS'(2);
		end else begin
			if (cmd.n_take) begin
				n_q <= quot;
			end
			if (cmd.mul_en) begin
				acc_q <= prod[VALUE_BITS-1:0];
			end
			if (cmd.d_next) begin
				d_q <= (d_q == VALUE_BITS'(2)) ? VALUE_BITS'(3) : d_q + VALUE_BITS'(2);
			end
		end
		if (cmd.sq_en) begin
			sq_q <= PW'(d_q) * PW'(d_q);
		end
		if (cmd.div_start) begin
			den_q <= (cmd.div_sel == DIV_ACC_BY_N) ? n_q : d_q;
		end
	end

	etu_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dividend),
		.divisor (den_q),
		.quot    (quot),
		.rem     (rem),
		.busy    (div_busy),
		.done    (div_done)
	);

	assign sts.sq_le_n  = sq_q <= PW'(n_q);
	assign sts.n_gt1    = n_q > VALUE_BITS'(1);
	assign sts.rem_zero = rem == '0;
	assign sts.div_done = div_done;
	assign sts.div_busy = div_busy;
	assign totient      = acc_q;
endmodule

/* hw/rtl/etu_ctrl.sv */
// Controller: sequences trial division, factor removal and result scaling.
module etu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  etu_pkg::etu_sts_t sts,
	output etu_pkg::etu_cmd_t cmd
);
	import etu_pkg::*;

	etu_state_t state_q;
	etu_state_t state_d;
	logic       hit_q;
	logic       fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hit: current divisor already removed from n; fin: leftover prime step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE) begin
				hit_q <= 1'b0;
				fin_q <= 1'b0;
			end else if (state_q == ST_EVN && sts.rem_zero) begin
				hit_q <= 1'b1;
			end else if (state_q == ST_MUL) begin
				hit_q <= 1'b0;
			end else if (state_q == ST_CHK && !sts.sq_le_n && sts.n_gt1) begin
				fin_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ:   state_d = ST_CHK;
			ST_CHK: begin
				if (sts.sq_le_n) begin
					state_d = ST_DIVN;
				end else if (sts.n_gt1) begin
					state_d = ST_DIVA;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIVN: begin
				if (sts.div_done) begin
					state_d = ST_EVN;
				end
			end
			ST_EVN: begin
				if (sts.rem_zero) begin
					state_d = ST_STN;
				end else if (hit_q) begin
					state_d = ST_DIVA;
				end else begin
					state_d = ST_SQ;
				end
			end
			ST_STN:  state_d = ST_DIVN;
			ST_DIVA: begin
				if (sts.div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = fin_q ? ST_DONE : ST_SQ;
			ST_DONE: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.div_sel = DIV_N_BY_D;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SQ: begin
				cmd.sq_en = 1'b1;
			end
			ST_CHK: begin
				if (sts.sq_le_n) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_N_BY_D;
				end else if (sts.n_gt1) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_ACC_BY_N;
				end
			end
			ST_DIVN: begin
				cmd.div_sel = DIV_N_BY_D;
			end
			ST_EVN: begin
				if (sts.rem_zero) begin
					cmd.n_take = 1'b1;
				end else if (hit_q) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_ACC_BY_D;
				end else begin
					cmd.d_next = 1'b1;
				end
			end
			ST_STN: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_N_BY_D;
			end
			ST_DIVA: begin
				cmd.div_sel = fin_q ? DIV_ACC_BY_N : DIV_ACC_BY_D;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.d_next = !fin_q;
			end
			ST_DONE: begin
				out_valid = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end
endmodule

/* hw/rtl/euler_totient_unit.sv */
// Euler totient unit: one value in, its totient phi(value) out, by trial division.
// Items are handled one at a time. After a value is accepted the unit tries
// 2 and then the odd divisors while d*d does not exceed the reduced value;
// each trial runs through the bit-serial divider (one quotient bit per
// cycle). Each prime factor found costs a further division per power removed
// and one more division to scale the result, and a leftover prime factor one
// more such scaling. For 20-bit values the worst case is roughly 512 trials.
// The result is held until taken, after which the next value is accepted.
// phi(0) is 0.
module euler_totient_unit #(
	parameter int VALUE_BITS = etu_pkg::VALUE_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	etu_value_if.sink     req,
	etu_totient_if.source rsp
);
	import etu_pkg::*;

	etu_cmd_t cmd;
	etu_sts_t sts;

	etu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	etu_datapath #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_value(req.value),
		.totient (rsp.totient)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("input taken while a result is pending");

	a_div_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider restarted while busy");

	a_load_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !req.ready && !rsp.valid)
		else $error("unit idle right after accepting an item");
endmodule
